### rtl/scba_pkg.sv
// ---------------------------------------------------------------------------
// Size class bitmap allocator package
// Shared widths, status and request codes, register indexes and reset values.
// ---------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS = 64;
   localparam int BIT_IDX_W = 6;

   // Item field widths
   localparam int REQ_TYPE_W = 1;
   localparam int SIZE_W     = 40;
   localparam int RCLASS_W   = 2;
   localparam int RIDX_W     = 10;
   localparam int STATUS_W   = 3;
   localparam int GCLASS_W   = 2;
   localparam int GIDX_W     = 10;
   localparam int BYTES_W    = 33;
   localparam int OFFSET_W   = 42;
   localparam int COUNT_W    = 11;

   // Parameter defaults
   localparam int DEF_NUM_CLASSES = 3;
   localparam int DEF_MAX_CHUNKS  = 1024;

   // Request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_ALLOC = 1'b0;
   localparam logic [REQ_TYPE_W-1:0] REQ_FREE  = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NONE_FREE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_UNUSED    = 3'd4;

   // Configuration port
   localparam int CSR_ADDR_W     = 6;
   localparam int CSR_DATA_W     = 64;
   localparam int CSR_IDX_LSB    = 3;
   localparam int CSR_IDX_W      = CSR_ADDR_W - CSR_IDX_LSB;
   localparam int CFG_CLASS_REGS = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SMALL_BYTES  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_BYTES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_BYTES  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SMALL_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LARGE_COUNT  = 3'd5;

   // Reset values
   localparam logic [BYTES_W-1:0] RST_SMALL_BYTES  = 33'd16384;
   localparam logic [BYTES_W-1:0] RST_MEDIUM_BYTES = 33'd1048576;
   localparam logic [BYTES_W-1:0] RST_LARGE_BYTES  = 33'd67108864;
   localparam logic [COUNT_W-1:0] RST_SMALL_COUNT  = 11'd640;
   localparam logic [COUNT_W-1:0] RST_MEDIUM_COUNT = 11'd640;
   localparam logic [COUNT_W-1:0] RST_LARGE_COUNT  = 11'd64;

   function automatic logic [BYTES_W-1:0] reset_chunk_bytes(input int c);
      logic [BYTES_W-1:0] v;
      case (c)
         0:       v = RST_SMALL_BYTES;
         1:       v = RST_MEDIUM_BYTES;
         2:       v = RST_LARGE_BYTES;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [COUNT_W-1:0] reset_chunk_count(input int c);
      logic [COUNT_W-1:0] v;
      case (c)
         0:       v = RST_SMALL_COUNT;
         1:       v = RST_MEDIUM_COUNT;
         2:       v = RST_LARGE_COUNT;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### rtl/scba_req_if.sv
// ---------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one alloc or free request item.
// ---------------------------------------------------------------------------
`default_nettype none

interface scba_req_if import scba_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [SIZE_W-1:0]     alloc_bytes;
   logic [RCLASS_W-1:0]   release_class;
   logic [RIDX_W-1:0]     release_index;

   modport source (output valid, output req_type, output alloc_bytes,
                   output release_class, output release_index, input ready);
   modport sink   (input valid, input req_type, input alloc_bytes,
                   input release_class, input release_index, output ready);
endinterface

`default_nettype wire

### rtl/scba_rsp_if.sv
// ---------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result item per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface scba_rsp_if import scba_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [GCLASS_W-1:0] granted_class;
   logic [GIDX_W-1:0]   granted_index;
   logic [BYTES_W-1:0]  granted_bytes;
   logic [OFFSET_W-1:0] byte_offset;

   modport source (output valid, output status, output granted_class,
                   output granted_index, output granted_bytes, output byte_offset,
                   input ready);
   modport sink   (input valid, input status, input granted_class,
                   input granted_index, input granted_bytes, input byte_offset,
                   output ready);
endinterface

`default_nettype wire

### rtl/scba_csr.sv
// ---------------------------------------------------------------------------
// Allocator configuration registers
// APB-style register block holding chunk size and chunk count per class.
// ---------------------------------------------------------------------------
`default_nettype none

module scba_csr import scba_pkg::*; #(
   parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0]                 paddr,
   input  wire logic [CSR_DATA_W-1:0]                 pwdata,
   output logic      [CSR_DATA_W-1:0]                 prdata,
   output logic                                       pready,
   output logic      [NUM_CLASSES-1:0][BYTES_W-1:0]   chunk_bytes,
   output logic      [NUM_CLASSES-1:0][COUNT_W-1:0]   chunk_count
);

   logic                 wr_en;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic [BYTES_W-1:0]   cfg_bytes [CFG_CLASS_REGS];
   logic [COUNT_W-1:0]   cfg_count [CFG_CLASS_REGS];

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[CSR_ADDR_W-1:CSR_IDX_LSB];

   for (genvar c = 0; c < CFG_CLASS_REGS; c++) begin : g_cfg
      if (c < NUM_CLASSES) begin : g_reg
         logic [BYTES_W-1:0] bytes_ff;
         logic [COUNT_W-1:0] count_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               bytes_ff <= reset_chunk_bytes(c);
               count_ff <= reset_chunk_count(c);
            end else if (wr_en) begin
               if (reg_idx == CSR_IDX_W'(int'(REG_SMALL_BYTES) + c)) begin
                  bytes_ff <= pwdata[BYTES_W-1:0];
               end
               if (reg_idx == CSR_IDX_W'(int'(REG_SMALL_COUNT) + c)) begin
                  count_ff <= pwdata[COUNT_W-1:0];
               end
            end
         end

         assign cfg_bytes[c] = bytes_ff;
         assign cfg_count[c] = count_ff;
      end else begin : g_none
         assign cfg_bytes[c] = '0;
         assign cfg_count[c] = '0;
      end
   end

   for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_out
      if (c < CFG_CLASS_REGS) begin : g_map
         assign chunk_bytes[c] = cfg_bytes[c];
         assign chunk_count[c] = cfg_count[c];
      end else begin : g_zero
         assign chunk_bytes[c] = '0;
         assign chunk_count[c] = '0;
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         REG_SMALL_BYTES:  prdata = CSR_DATA_W'(cfg_bytes[0]);
         REG_MEDIUM_BYTES: prdata = CSR_DATA_W'(cfg_bytes[1]);
         REG_LARGE_BYTES:  prdata = CSR_DATA_W'(cfg_bytes[2]);
         REG_SMALL_COUNT:  prdata = CSR_DATA_W'(cfg_count[0]);
         REG_MEDIUM_COUNT: prdata = CSR_DATA_W'(cfg_count[1]);
         REG_LARGE_COUNT:  prdata = CSR_DATA_W'(cfg_count[2]);
         default:          prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

### rtl/size_class_bitmap_allocator.sv
// Sequence: a valid free reads the word holding the released bit, then checks and
//   clears that bit, then loads the result; an alloc tests classes in order for fit,
//   scans bitmap words of that class and the classes after it, then loads the result.
// Throughput: one item at a time; the next item is taken once the result is in
//   the output register. Scan rate is one bitmap word per cycle on the read port.
// Reset: synchronous; a clearing pass zeroes each bitmap word in turn before the first accept.
// ---------------------------------------------------------------------------
// Size class bitmap allocator
// Chunk allocator with per-class use bitmaps held in one synchronous memory.
// ---------------------------------------------------------------------------
`default_nettype none

module size_class_bitmap_allocator import scba_pkg::*; #(
   parameter int NUM_CLASSES          = DEF_NUM_CLASSES,
   parameter int MAX_CHUNKS_PER_CLASS = DEF_MAX_CHUNKS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   scba_req_if.sink                   req_chan,
   scba_rsp_if.source                 rsp_chan,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // Bitmap geometry: each class owns WPC consecutive words.
   localparam int WPC     = (MAX_CHUNKS_PER_CLASS + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH   = NUM_CLASSES * WPC;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WORD_W  = (WPC > 1) ? $clog2(WPC) : 1;
   localparam int WCNT_W  = WORD_W + 1;
   localparam int IDX_W   = WORD_W + BIT_IDX_W;
   localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CMP_W   = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
   localparam int PROD_W  = IDX_W + BYTES_W;
   localparam int IDXX_W  = (IDX_W > GIDX_W) ? IDX_W : GIDX_W;

   // Sequencer states
   localparam logic [2:0] S_CLEAR = 3'd0;  // zero the bitmap after reset
   localparam logic [2:0] S_IDLE  = 3'd1;  // wait for an item
   localparam logic [2:0] S_SEL   = 3'd2;  // find the first class that fits
   localparam logic [2:0] S_SCAN  = 3'd3;  // walk bitmap words of one class
   localparam logic [2:0] S_FREE  = 3'd4;  // check and clear the released bit
   localparam logic [2:0] S_DONE  = 3'd5;  // hand result to the output register

   // Configuration
   logic [NUM_CLASSES-1:0][BYTES_W-1:0] chunk_bytes;
   logic [NUM_CLASSES-1:0][COUNT_W-1:0] chunk_count;

   scba_csr #(
      .NUM_CLASSES (NUM_CLASSES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .chunk_bytes (chunk_bytes),
      .chunk_count (chunk_count)
   );

   // Control registers
   logic [2:0]          state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [CLS_W-1:0]    cls_ff, cls_in;
   logic [WCNT_W-1:0]   wi_ff, wi_in;      // next word to read
   logic [WORD_W-1:0]   we_ff, we_in;      // word whose data is in rd_data_ff
   logic                pend_ff, pend_in;  // read data valid for we_ff
   logic                rsp_valid_ff, rsp_valid_in;

   // Result staging
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CLS_W-1:0]    res_cls_ff, res_cls_in;
   logic [IDX_W-1:0]    res_idx_ff, res_idx_in;
   logic [BYTES_W-1:0]  res_bytes_ff, res_bytes_in;

   // Latched request payload
   logic [SIZE_W-1:0]    size_ff;
   logic [BIT_IDX_W-1:0] rbit_ff;

   // Output register
   logic [STATUS_W-1:0] out_status_ff;
   logic [GCLASS_W-1:0] out_class_ff;
   logic [GIDX_W-1:0]   out_index_ff;
   logic [BYTES_W-1:0]  out_bytes_ff;
   logic [OFFSET_W-1:0] out_offset_ff;
   logic                out_load;

   // Bitmap memory ports
   logic [WORD_BITS-1:0] bitmap_mem [DEPTH];
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic [WORD_BITS-1:0] rd_data_ff;

   // Scan datapath
   logic                 req_accept;
   logic                 rel_ok;
   logic [CMP_W-1:0]     lim;
   logic [COUNT_W-1:0]   cur_count;
   logic                 issue_ok;
   logic                 word_full;
   logic [BIT_IDX_W-1:0] zero_pos;
   logic [IDX_W-1:0]     free_idx;
   logic [PROD_W-1:0]    prod;
   logic [IDXX_W-1:0]    idx_ext;

   function automatic logic [ADDR_W-1:0] word_addr(input logic [CLS_W-1:0]  c,
                                                   input logic [WORD_W-1:0] w);
      return ADDR_W'(32'(c) * WPC + 32'(w));
   endfunction

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Release target must name an existing class and chunk slot.
   assign rel_ok = (32'(req_chan.release_class) < NUM_CLASSES) &&
                   (32'(req_chan.release_index) < MAX_CHUNKS_PER_CLASS);

   // Effective chunk count of the class under scan, capped at capacity.
   assign cur_count = chunk_count[cls_ff];
   assign lim = (CMP_W'(cur_count) > CMP_W'(MAX_CHUNKS_PER_CLASS)) ?
                CMP_W'(MAX_CHUNKS_PER_CLASS) : CMP_W'(cur_count);

   // A word is worth reading only if its first chunk lies below the limit.
   assign issue_ok = CMP_W'({wi_ff, {BIT_IDX_W{1'b0}}}) < lim;

   assign word_full = &rd_data_ff;

   // Lowest clear bit of the word just read.
   always_comb begin
      zero_pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!rd_data_ff[b]) begin
            zero_pos = BIT_IDX_W'(b);
         end
      end
   end

   assign free_idx = {we_ff, zero_pos};

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cls_in        = cls_ff;
      wi_in         = wi_ff;
      we_in         = we_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_cls_in    = res_cls_ff;
      res_idx_in    = res_idx_ff;
      res_bytes_in  = res_bytes_ff;
      mem_we        = 1'b0;
      mem_waddr     = clr_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = word_addr(cls_ff, wi_ff[WORD_W-1:0]);
      out_load      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_accept) begin
               cls_in       = '0;
               wi_in        = '0;
               pend_in      = 1'b0;
               res_cls_in   = '0;
               res_idx_in   = '0;
               res_bytes_in = '0;
               if (req_chan.req_type == REQ_FREE) begin
                  if (rel_ok) begin
                     // Fetch the word that holds the released bit.
                     cls_in    = CLS_W'(req_chan.release_class);
                     we_in     = WORD_W'(req_chan.release_index >> BIT_IDX_W);
                     mem_re    = 1'b1;
                     mem_raddr = word_addr(CLS_W'(req_chan.release_class),
                                           WORD_W'(req_chan.release_index >> BIT_IDX_W));
                     state_in  = S_FREE;
                  end else begin
                     res_status_in = ST_UNUSED;
                     state_in      = S_DONE;
                  end
               end else begin
                  state_in = S_SEL;
               end
            end
         end

         S_SEL: begin
            // Walk classes in order until one chunk size holds the request.
            if (SIZE_W'(chunk_bytes[cls_ff]) >= size_ff) begin
               state_in = S_SCAN;
            end else if (cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
               res_status_in = ST_TOO_LARGE;
               state_in      = S_DONE;
            end else begin
               cls_in = cls_ff + 1'b1;
            end
         end

         S_SCAN: begin
            // Evaluate last cycle's word while reading the next one.
            if (pend_ff && !word_full) begin
               if (CMP_W'(free_idx) < lim) begin
                  mem_we        = 1'b1;
                  mem_waddr     = word_addr(cls_ff, we_ff);
                  mem_wdata     = rd_data_ff |
                                  ({{(WORD_BITS-1){1'b0}}, 1'b1} << zero_pos);
                  res_status_in = ST_GRANTED;
                  res_cls_in    = cls_ff;
                  res_idx_in    = free_idx;
                  res_bytes_in  = chunk_bytes[cls_ff];
                  state_in      = S_DONE;
               end else if (cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
                  res_status_in = ST_NONE_FREE;
                  state_in      = S_DONE;
               end else begin
                  cls_in  = cls_ff + 1'b1;
                  wi_in   = '0;
                  pend_in = 1'b0;
               end
            end else if (issue_ok) begin
               mem_re    = 1'b1;
               mem_raddr = word_addr(cls_ff, wi_ff[WORD_W-1:0]);
               we_in     = wi_ff[WORD_W-1:0];
               wi_in     = wi_ff + 1'b1;
               pend_in   = 1'b1;
            end else if (pend_ff) begin
               // Full word pending and nothing left to read: drop the pending word.
               pend_in = 1'b0;
            end else if (cls_ff == CLS_W'(NUM_CLASSES - 1)) begin
               res_status_in = ST_NONE_FREE;
               state_in      = S_DONE;
            end else begin
               // Class exhausted: move to the next larger class.
               cls_in = cls_ff + 1'b1;
               wi_in  = '0;
            end
         end

         S_FREE: begin
            if (rd_data_ff[rbit_ff]) begin
               mem_we        = 1'b1;
               mem_waddr     = word_addr(cls_ff, we_ff);
               mem_wdata     = rd_data_ff &
                               ~({{(WORD_BITS-1){1'b0}}, 1'b1} << rbit_ff);
               res_status_in = ST_FREED;
            end else begin
               res_status_in = ST_UNUSED;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free, then load it.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         cls_ff        <= '0;
         wi_ff         <= '0;
         we_ff         <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         res_status_ff <= ST_GRANTED;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         cls_ff        <= cls_in;
         wi_ff         <= wi_in;
         we_ff         <= we_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
         res_status_ff <= res_status_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      res_cls_ff   <= res_cls_in;
      res_idx_ff   <= res_idx_in;
      res_bytes_ff <= res_bytes_in;
      if (req_accept) begin
         size_ff <= req_chan.alloc_bytes;
         rbit_ff <= req_chan.release_index[BIT_IDX_W-1:0];
      end
   end

   // Bitmap memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= bitmap_mem[mem_raddr];
      end
   end

   // Output register, with the offset product formed on load.
   assign prod    = res_idx_ff * res_bytes_ff;
   assign idx_ext = IDXX_W'(res_idx_ff);

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_status_ff <= res_status_ff;
         out_class_ff  <= GCLASS_W'(res_cls_ff);
         out_index_ff  <= idx_ext[GIDX_W-1:0];
         out_bytes_ff  <= res_bytes_ff;
         out_offset_ff <= OFFSET_W'(prod);
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.granted_class = out_class_ff;
   assign rsp_chan.granted_index = out_index_ff;
   assign rsp_chan.granted_bytes = out_bytes_ff;
   assign rsp_chan.byte_offset   = out_offset_ff;

   // Assertions
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_chan.ready)
      else $error("item accepted during bitmap clearing pass");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_we) |->
         (32'(free_idx) < MAX_CHUNKS_PER_CLASS) && (CMP_W'(free_idx) < lim))
      else $error("granted chunk outside class limit");

   a_non_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (out_load && res_status_ff != ST_GRANTED) |=>
         (rsp_chan.byte_offset == '0) && (rsp_chan.granted_bytes == '0) &&
         (rsp_chan.granted_index == '0))
      else $error("non-granted result carries nonzero fields");

   a_free_sets_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE) |=> (state_ff == S_DONE) &&
         (res_status_ff == ST_FREED || res_status_ff == ST_UNUSED))
      else $error("free request produced wrong status");

endmodule

`default_nettype wire
